### sv/kva_pkg.sv
// Shared constants, types and the tone table of the keyboard voice allocator.
package kva_pkg;

    localparam int NUM_VOICES = 4;
    localparam int ROWS       = 4;
    localparam int COLS       = 4;

    // At most sixteen keys are scanned, the width of the snapshot.
    localparam int NKEYS   = (ROWS * COLS < 16) ? ROWS * COLS : 16;
    localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W   = $clog2(NUM_VOICES + 1);

    localparam logic [3:0] KEY_UP   = 4'd0;
    localparam logic [3:0] KEY_DOWN = 4'd1;
    localparam logic [3:0] NOTE_LO  = 4'd2;
    localparam logic [3:0] NOTE_HI  = 4'd14;
    localparam logic [3:0] LAST_KEY = 4'(NKEYS - 1);

    localparam logic [2:0] OCT_MIN   = 3'd1;
    localparam logic [2:0] OCT_MAX   = 3'd7;
    localparam logic [2:0] OCT_RESET = 3'd4;

    localparam int NOTES_PER_OCT = 13;
    localparam int ROM_DEPTH     = 91;

    // Equal-temperament tones in hertz, one row of thirteen notes per octave.
    localparam logic [12:0] FREQ_ROM [0:ROM_DEPTH-1] = '{
          13'd33,   13'd35,   13'd37,   13'd39,   13'd41,   13'd44,   13'd46,
          13'd49,   13'd52,   13'd55,   13'd58,   13'd62,   13'd65,
          13'd65,   13'd69,   13'd73,   13'd78,   13'd82,   13'd87,   13'd92,
          13'd98,  13'd104,  13'd110,  13'd117,  13'd123,  13'd131,
         13'd131,  13'd139,  13'd147,  13'd156,  13'd165,  13'd175,  13'd185,
         13'd196,  13'd208,  13'd220,  13'd233,  13'd247,  13'd262,
         13'd262,  13'd277,  13'd294,  13'd311,  13'd330,  13'd349,  13'd370,
         13'd392,  13'd415,  13'd440,  13'd466,  13'd494,  13'd523,
         13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,  13'd740,
         13'd784,  13'd831,  13'd880,  13'd932,  13'd988, 13'd1047,
        13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397, 13'd1480,
        13'd1568, 13'd1661, 13'd1760, 13'd1865, 13'd1976, 13'd2093,
        13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794, 13'd2960,
        13'd3136, 13'd3322, 13'd3520, 13'd3729, 13'd3951, 13'd4186
    };

    // One voice command as it waits between the scan and the output.
    typedef struct packed {
        logic [1:0]  voice;
        logic [12:0] frequency;
        logic        note_on;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

endpackage

### sv/kva_tone.sv
// Tone lookup: octave and note key to frequency in hertz.
module kva_tone
    import kva_pkg::*;
(
    input  logic [2:0]  octave,
    input  logic [3:0]  key,
    output logic [12:0] frequency
);

    logic [2:0] oct_clamped;
    logic [3:0] note_ofs;
    logic [6:0] rom_idx;

    // Clamp the octave and keep the note offset inside one table row.
    always_comb
    begin
        if (octave < OCT_MIN)
            oct_clamped = OCT_MIN;
        else if (octave > OCT_MAX)
            oct_clamped = OCT_MAX;
        else
            oct_clamped = octave;

        if (key >= NOTE_LO && key <= NOTE_HI)
            note_ofs = key - NOTE_LO;
        else
            note_ofs = 4'd0;

        rom_idx = 7'(oct_clamped - OCT_MIN) * 7'(NOTES_PER_OCT) + 7'(note_ofs);
    end

    assign frequency = FREQ_ROM[rom_idx];

endmodule

### sv/keyboard_voice_allocator.sv
// Top level of the keyboard voice allocator: key scan sequencer and command output.
//
// Usage: each request on the key channel (key_valid, key_stall, key_pressed)
// carries one snapshot of the key matrix, bit row*COLS+col set while held.
// The block walks the keys in code order, one key per clock cycle unless a full
// output register holds the scan, through a single shared compare, voice search
// and tone lookup. Keys 0 and 1 step the octave, keys 2 to 14 start or stop
// voices, and each voice change becomes a request on the command channel
// (cmd_valid, cmd_stall, voice, frequency, note_on, last). last marks the final
// command caused by one snapshot. When the command channel takes every request
// at once, key_stall is high through the 16 scan steps and one closing step
// after a snapshot is taken, then low in the idle state until the next one. The
// final command of a snapshot becomes valid when the closing step moves it to
// the output register. A command is held back in the pending register until the
// next command or the closing step, so that last can be set on it, then waits in
// the output register until taken. While the receiver stalls, a full output
// register makes the scan wait on the next key that needs a command, or the
// closing step wait. After reset all keys are released, all voices are free, the
// octave is 4 and no command is pending.
module keyboard_voice_allocator
    import kva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        key_valid,
    output logic        key_stall,
    input  logic [15:0] key_pressed,

    output logic        cmd_valid,
    input  logic        cmd_stall,
    output logic [1:0]  voice,
    output logic [12:0] frequency,
    output logic        note_on,
    output logic        last
);

    state_t state_reg, state_next;

    logic [15:0]        snap_reg;
    logic [3:0]         key_reg;
    logic [15:0]        held_reg;
    logic [VOICE_W-1:0] key_voice_reg [16];
    logic [NUM_VOICES-1:0] busy_reg;
    logic [CNT_W-1:0]   busy_cnt_reg;
    logic [2:0]         octave_reg;

    logic               pend_valid_reg;
    cmd_t               pend_reg;
    logic               out_valid_reg;
    cmd_t               out_reg;
    logic               out_last_reg;

    logic               down, held, is_note, press, rel;
    logic               free_found;
    logic [VOICE_W-1:0] free_voice;
    logic [VOICE_W-1:0] rel_voice;
    logic               start_note, stop_note, oct_up, oct_down, emit;
    logic               out_free, hold, step, key_take;
    logic [12:0]        tone;
    cmd_t               new_cmd;

    kva_tone u_tone (
        .octave    (octave_reg),
        .key       (key_reg),
        .frequency (tone)
    );

    // Lowest free voice.
    always_comb
    begin
        free_found = 1'b0;
        free_voice = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--)
        begin
            if (!busy_reg[v])
            begin
                free_found = 1'b1;
                free_voice = VOICE_W'(v);
            end
        end
    end

    // Decode what the current key does in this scan step.
    always_comb
    begin
        down       = snap_reg[key_reg];
        held       = held_reg[key_reg];
        is_note    = (key_reg >= NOTE_LO) && (key_reg <= NOTE_HI);
        press      = down && !held;
        rel        = !down && held;
        rel_voice  = key_voice_reg[key_reg];
        start_note = press && is_note && (busy_cnt_reg < CNT_W'(NUM_VOICES)) && free_found;
        stop_note  = rel && is_note;
        oct_up     = press && (key_reg == KEY_UP) && (octave_reg < OCT_MAX);
        oct_down   = press && (key_reg == KEY_DOWN) && (octave_reg > OCT_MIN);
        emit       = start_note || stop_note;

        new_cmd.voice     = start_note ? 2'(free_voice) : 2'(rel_voice);
        new_cmd.frequency = start_note ? tone : 13'd0;
        new_cmd.note_on   = start_note;

        out_free = !out_valid_reg || !cmd_stall;
        hold     = emit && pend_valid_reg && !out_free;
        step     = (state_reg == ST_SCAN) && !hold;
        key_take = key_valid && !key_stall;
    end

    // Scan sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (key_take)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (step && key_reg == LAST_KEY)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign key_stall = (state_reg != ST_IDLE);

    // Control state and the key and voice bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_reg        <= '0;
            held_reg       <= '0;
            busy_reg       <= '0;
            busy_cnt_reg   <= '0;
            octave_reg     <= OCT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < 16; k++)
                key_voice_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (key_take)
                key_reg <= '0;
            else if (step)
                key_reg <= key_reg + 4'd1;

            if (step)
            begin
                if (start_note)
                begin
                    busy_reg[free_voice]   <= 1'b1;
                    key_voice_reg[key_reg] <= free_voice;
                    held_reg[key_reg]      <= 1'b1;
                    busy_cnt_reg           <= busy_cnt_reg + CNT_W'(1);
                end
                else if (stop_note)
                begin
                    if (32'(rel_voice) < NUM_VOICES)
                        busy_reg[rel_voice] <= 1'b0;
                    if (busy_cnt_reg != '0)
                        busy_cnt_reg <= busy_cnt_reg - CNT_W'(1);
                    key_voice_reg[key_reg] <= '0;
                    held_reg[key_reg]      <= 1'b0;
                end
                else if (oct_up)
                begin
                    octave_reg        <= octave_reg + 3'd1;
                    held_reg[key_reg] <= 1'b1;
                end
                else if (oct_down)
                begin
                    octave_reg        <= octave_reg - 3'd1;
                    held_reg[key_reg] <= 1'b1;
                end
                else if (rel)
                    held_reg[key_reg] <= 1'b0;
            end

            // Pending command and output register.
            if (step && emit)
            begin
                pend_valid_reg <= 1'b1;
                out_valid_reg  <= pend_valid_reg || (out_valid_reg && cmd_stall);
            end
            else if (state_reg == ST_FLUSH && pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !cmd_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Snapshot and command payload registers.
    always_ff @(posedge clk)
    begin
        if (key_take)
            snap_reg <= key_pressed;

        if (step && emit)
        begin
            pend_reg <= new_cmd;
            if (pend_valid_reg)
            begin
                out_reg      <= pend_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_FLUSH && pend_valid_reg && out_free)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign cmd_valid = out_valid_reg;
    assign voice     = out_reg.voice;
    assign frequency = out_reg.frequency;
    assign note_on   = out_reg.note_on;
    assign last      = out_last_reg;

    // The busy count always matches the busy voices.
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(busy_cnt_reg) == $countones(busy_reg))
        else $error("busy count does not match busy voices");

    // The octave stays within its range.
    a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
        octave_reg >= OCT_MIN && octave_reg <= OCT_MAX)
        else $error("octave out of range");

    // No command is left pending once the block is idle.
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("command pending while idle");

    // A scan step held back by a full output keeps its key.
    a_hold_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hold) |=> $stable(key_reg))
        else $error("scan advanced while output was full");

endmodule
